/* design/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// Types, constants and helpers shared by the cache tag controller modules.
// ----------------------------------------------------------------------------
package salc_pkg;

	localparam int WAY_OUT_W  = 3;
	localparam int CNT_W      = 32;
	localparam int RANK_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	// configuration reset values
	localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 4'd4;
	localparam logic [CFG_DATA_W-1:0] INDEX_BITS_RST  = 4'd6;
	localparam logic [CFG_DATA_W-1:0] WAYS_IN_USE_RST = 4'd4;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic              valid;
		logic              dirty;
		logic [RANK_W-1:0] rank;
	} meta_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic req_ready;
		logic clear_wr;
		logic accept;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic req_valid;
		logic clear_last;
		logic out_free;
	} status_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == '1) ? v : v + cnt_t'(1);
	endfunction

endpackage

/* design/salc_req_if.sv */
// ----------------------------------------------------------------------------
// salc_req_if
// Access request channel: read/write kind and byte address.
// ----------------------------------------------------------------------------
interface salc_req_if #(
	parameter int ADDR_BITS = 24
);
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [ADDR_BITS-1:0] address;

	modport source (output valid, output kind, output address, input ready);
	modport sink   (input valid, input kind, input address, output ready);
endinterface

/* design/salc_rsp_if.sv */
// ----------------------------------------------------------------------------
// salc_rsp_if
// Access result channel: hit, way, writeback flag and running statistics.
// ----------------------------------------------------------------------------
interface salc_rsp_if;
	import salc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [WAY_OUT_W-1:0] way;
	logic                 writeback;
	cnt_t                 access_count;
	cnt_t                 read_count;
	cnt_t                 hit_count;
	cnt_t                 read_hit_count;
	cnt_t                 write_hit_count;

	modport source (
		output valid, output hit, output way, output writeback,
		output access_count, output read_count, output hit_count,
		output read_hit_count, output write_hit_count,
		input ready
	);
	modport sink (
		input valid, input hit, input way, input writeback,
		input access_count, input read_count, input hit_count,
		input read_hit_count, input write_hit_count,
		output ready
	);
endinterface

/* design/salc_cfg_if.sv */
// ----------------------------------------------------------------------------
// salc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface salc_cfg_if;
	import salc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/salc_ctrl.sv */
// ----------------------------------------------------------------------------
// salc_ctrl
// Controller: clearing sweep after reset, then lookup and update of one
// access at a time.
// ----------------------------------------------------------------------------
module salc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  salc_pkg::status_t status,
	output salc_pkg::cmd_t    cmd
);
	import salc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (status.req_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			ST_IDLE: begin
				cmd.req_ready = 1'b1;
				cmd.accept    = status.req_valid;
			end
			ST_UPDATE: begin
				cmd.commit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* design/salc_dp.sv */
// ----------------------------------------------------------------------------
// salc_dp
// Datapath: configuration registers, address split, tag and state memories,
// way compare, LRU rank update, result register and statistics counters.
// ----------------------------------------------------------------------------
module salc_dp #(
	parameter int ADDR_BITS = 24,
	parameter int MAX_WAYS  = 8,
	parameter int MAX_SETS  = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	salc_req_if.sink          req,
	salc_rsp_if.source        rsp,
	salc_cfg_if.sink          cfg,
	input  salc_pkg::cmd_t    cmd,
	output salc_pkg::status_t status
);
	import salc_pkg::*;

	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NWAY_W  = $clog2(MAX_WAYS + 1);
	localparam int IDX_LIM = $clog2(MAX_SETS + 1) - 1;

	// configuration
	logic [CFG_DATA_W-1:0] offset_bits_q;
	logic [CFG_DATA_W-1:0] index_bits_q;
	logic [CFG_DATA_W-1:0] ways_in_use_q;

	// memories
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem [MAX_SETS];
	meta_t [MAX_WAYS-1:0]               meta_mem [MAX_SETS];

	// clearing sweep
	logic [SET_W-1:0] clr_q;

	// address split
	logic [CFG_DATA_W-1:0] ib_eff;
	logic [4:0]            tag_shift;
	logic [ADDR_BITS-1:0]  set_field;
	logic [SET_W-1:0]      set_in;
	logic [ADDR_BITS-1:0]  tag_in;

	// lookup stage
	logic                               kind_s1;
	logic [SET_W-1:0]                   set_s1;
	logic [ADDR_BITS-1:0]               tag_s1;
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_rd_s1;
	meta_t [MAX_WAYS-1:0]               meta_rd_s1;

	// update logic
	logic [NWAY_W-1:0]    nways;
	logic [MAX_WAYS-1:0]  in_use;
	logic [MAX_WAYS-1:0]  match;
	logic                 is_hit;
	logic [WAY_W-1:0]     hit_way;
	logic [RANK_W-1:0]    min_rank;
	logic                 min_found;
	logic [WAY_W-1:0]     victim_way;
	logic [WAY_W-1:0]     sel_way;
	logic [RANK_W-1:0]    sel_rank;
	logic                 wb;
	meta_t [MAX_WAYS-1:0] meta_new;
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_new;
	meta_t [MAX_WAYS-1:0] meta_clr;
	logic                 meta_we;
	logic [SET_W-1:0]     meta_addr;
	meta_t [MAX_WAYS-1:0] meta_wdata;

	// result and statistics
	logic                 rsp_valid_q;
	logic                 hit_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic                 wb_q;
	cnt_t                 acc_cnt_q;
	cnt_t                 rd_cnt_q;
	cnt_t                 hit_cnt_q;
	cnt_t                 rd_hit_cnt_q;
	cnt_t                 wr_hit_cnt_q;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_BITS_RST;
			index_bits_q  <= INDEX_BITS_RST;
			ways_in_use_q <= WAYS_IN_USE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_OFFSET_BITS: offset_bits_q <= cfg.data;
				CFG_INDEX_BITS:  index_bits_q  <= cfg.data;
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// address split on the incoming request
	always_comb begin
		ib_eff    = (int'(index_bits_q) > IDX_LIM) ? CFG_DATA_W'(IDX_LIM) : index_bits_q;
		tag_shift = 5'(offset_bits_q) + 5'(ib_eff);
		set_field = (req.address >> offset_bits_q) & ~({ADDR_BITS{1'b1}} << ib_eff);
		set_in    = SET_W'(set_field);
		tag_in    = req.address >> tag_shift;
	end

	assign req.ready = cmd.req_ready;

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + SET_W'(1);
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_WAYS; k++) begin
			meta_clr[k].valid = 1'b0;
			meta_clr[k].dirty = 1'b0;
			meta_clr[k].rank  = RANK_W'(k);
		end
	end

	// lookup stage registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_s1 <= req.kind;
			set_s1  <= set_in;
			tag_s1  <= tag_in;
		end
	end

	// tag memory
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tag_rd_s1 <= tag_mem[set_in];
		end
		if (cmd.commit) begin
			tag_mem[set_s1] <= tag_new;
		end
	end

	// valid, dirty and rank memory
	assign meta_we    = cmd.commit | cmd.clear_wr;
	assign meta_addr  = cmd.clear_wr ? clr_q : set_s1;
	assign meta_wdata = cmd.clear_wr ? meta_clr : meta_new;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			meta_rd_s1 <= meta_mem[set_in];
		end
		if (meta_we) begin
			meta_mem[meta_addr] <= meta_wdata;
		end
	end

	// way compare, victim choice and rank update
	always_comb begin
		if (ways_in_use_q == '0) begin
			nways = NWAY_W'(1);
		end else if (int'(ways_in_use_q) > MAX_WAYS) begin
			nways = NWAY_W'(MAX_WAYS);
		end else begin
			nways = NWAY_W'(ways_in_use_q);
		end

		for (int k = 0; k < MAX_WAYS; k++) begin
			in_use[k] = (k < int'(nways));
			match[k]  = in_use[k] & meta_rd_s1[k].valid & (tag_rd_s1[k] == tag_s1);
		end
		is_hit = |match;

		hit_way = '0;
		for (int k = MAX_WAYS - 1; k >= 0; k--) begin
			if (match[k]) hit_way = WAY_W'(k);
		end

		// lowest rank present among ways in use
		min_rank  = '0;
		min_found = 1'b0;
		for (int v = 0; v < (1 << RANK_W); v++) begin
			for (int k = 0; k < MAX_WAYS; k++) begin
				if (!min_found && in_use[k] && (meta_rd_s1[k].rank == RANK_W'(v))) begin
					min_rank  = RANK_W'(v);
					min_found = 1'b1;
				end
			end
		end

		victim_way = '0;
		for (int k = MAX_WAYS - 1; k >= 0; k--) begin
			if (in_use[k] && (meta_rd_s1[k].rank == min_rank)) victim_way = WAY_W'(k);
		end

		sel_way  = is_hit ? hit_way : victim_way;
		sel_rank = meta_rd_s1[sel_way].rank;
		wb       = !is_hit && meta_rd_s1[sel_way].valid && meta_rd_s1[sel_way].dirty;

		meta_new = meta_rd_s1;
		tag_new  = tag_rd_s1;
		for (int k = 0; k < MAX_WAYS; k++) begin
			if (in_use[k] && (meta_rd_s1[k].rank > sel_rank)) begin
				meta_new[k].rank = meta_rd_s1[k].rank - RANK_W'(1);
			end
		end
		meta_new[sel_way].rank  = RANK_W'(int'(nways) - 1);
		meta_new[sel_way].valid = 1'b1;
		meta_new[sel_way].dirty = is_hit ? (meta_rd_s1[sel_way].dirty | kind_s1) : kind_s1;
		if (!is_hit) begin
			tag_new[sel_way] = tag_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= is_hit;
			way_q <= WAY_OUT_W'(sel_way);
			wb_q  <= wb;
		end
	end

	// statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q    <= '0;
			rd_cnt_q     <= '0;
			hit_cnt_q    <= '0;
			rd_hit_cnt_q <= '0;
			wr_hit_cnt_q <= '0;
		end else if (cmd.commit) begin
			acc_cnt_q <= sat_inc(acc_cnt_q);
			if (!kind_s1) rd_cnt_q <= sat_inc(rd_cnt_q);
			if (is_hit) begin
				hit_cnt_q <= sat_inc(hit_cnt_q);
				if (kind_s1) begin
					wr_hit_cnt_q <= sat_inc(wr_hit_cnt_q);
				end else begin
					rd_hit_cnt_q <= sat_inc(rd_hit_cnt_q);
				end
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.hit             = hit_q;
	assign rsp.way             = way_q;
	assign rsp.writeback       = wb_q;
	assign rsp.access_count    = acc_cnt_q;
	assign rsp.read_count      = rd_cnt_q;
	assign rsp.hit_count       = hit_cnt_q;
	assign rsp.read_hit_count  = rd_hit_cnt_q;
	assign rsp.write_hit_count = wr_hit_cnt_q;

	assign status.req_valid  = req.valid;
	assign status.clear_last = (clr_q == SET_W'(MAX_SETS - 1));
	assign status.out_free   = !rsp_valid_q || rsp.ready;

`ifndef NO_ASSERTIONS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("result not presented after update");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !cmd.accept)
		else $error("request taken while previous still in lookup");

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> !rsp.writeback)
		else $error("writeback flagged on a hit");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (acc_cnt_q != '0))
		else $error("access count zero after an access");

	a_stats_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(acc_cnt_q) && $stable(hit_cnt_q))
		else $error("statistics changed while result waiting");
`endif

endmodule

/* design/set_assoc_lru_cache_tags.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag controller for a set-associative cache with per-way LRU rank counters.
// After reset the block runs a clearing pass over every set of its set
// memory and takes no request until it ends; configuration writes are taken
// throughout. For each access the set is read from single-port memory on
// the cycle the request is taken; then, once the output register is free,
// the ways in use are compared, the victim and new ranks chosen and the set
// written back, with the result loaded into an output register. A result
// that waits to be taken holds the update of the following access.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
	parameter int ADDR_BITS = 24,
	parameter int MAX_WAYS  = 8,
	parameter int MAX_SETS  = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	salc_req_if.sink   req,
	salc_rsp_if.source rsp,
	salc_cfg_if.sink   cfg
);
	import salc_pkg::*;

	cmd_t    cmd;
	status_t status;

	salc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	salc_dp #(
		.ADDR_BITS (ADDR_BITS),
		.MAX_WAYS  (MAX_WAYS),
		.MAX_SETS  (MAX_SETS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

endmodule
